// ===== hw/rtl/rpa_pkg.sv =====
package rpa_pkg;

  localparam int ROT_W    = 16;
  localparam int STEP_W   = 32;
  localparam int POSE_T_W = 40;

  // rotation dot product: three Q4.28 products plus rounding offset
  localparam int RPROD_W  = 2 * ROT_W;
  localparam int RSUM_W   = RPROD_W + 2;
  // translation dot product: three Q34.14 products plus rounding offset
  localparam int TPROD_W  = ROT_W + STEP_W;
  localparam int TSUM_W   = TPROD_W + 2;
  localparam int TRND_W   = TSUM_W - 14;
  localparam int TTOT_W   = POSE_T_W + 1;

  localparam int FRAC_SHIFT = 14;
  localparam int ROUND_HALF = 1 << (FRAC_SHIFT - 1);

  localparam logic signed [ROT_W-1:0] ONE_Q14 = 16'sd16384;
  localparam logic signed [ROT_W-1:0] ROT_MAX = 16'sh7FFF;
  localparam logic signed [ROT_W-1:0] ROT_MIN = 16'sh8000;

  localparam logic signed [POSE_T_W-1:0] POSE_T_MAX = {1'b0, {(POSE_T_W-1){1'b1}}};
  localparam logic signed [POSE_T_W-1:0] POSE_T_MIN = {1'b1, {(POSE_T_W-1){1'b0}}};

  typedef logic signed [ROT_W-1:0]    rot_t;
  typedef logic signed [STEP_W-1:0]   step_t;
  typedef logic signed [POSE_T_W-1:0] pose_t_t;

endpackage

// ===== hw/rtl/rigid_pose_accumulator.sv =====
// Channel | Ports                                   | Direction
// --------+-----------------------------------------+----------
// in      | in_valid, in_ready, in_rot_*, in_step_* | request in
// out     | out_valid, out_ready, out_r*, out_t*    | pose out
//
// One request per cycle sustained while out_ready holds; out_valid rises once a request has passed
// the input register and one pass of 3-term dot products into the result register.
// The pose registers update in the same edge that loads the result register.
// Reset (rst_n low, synchronous) sets the pose to identity / zero and empties both stages.
// A stalled result holds; the input register still takes one request behind it.
module rigid_pose_accumulator (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  rpa_pkg::rot_t           in_rot_00,
  input  rpa_pkg::rot_t           in_rot_01,
  input  rpa_pkg::rot_t           in_rot_02,
  input  rpa_pkg::rot_t           in_rot_10,
  input  rpa_pkg::rot_t           in_rot_11,
  input  rpa_pkg::rot_t           in_rot_12,
  input  rpa_pkg::rot_t           in_rot_20,
  input  rpa_pkg::rot_t           in_rot_21,
  input  rpa_pkg::rot_t           in_rot_22,
  input  rpa_pkg::step_t          in_step_tx,
  input  rpa_pkg::step_t          in_step_ty,
  input  rpa_pkg::step_t          in_step_tz,
  output logic                    out_valid,
  input  logic                    out_ready,
  output rpa_pkg::rot_t           out_r00,
  output rpa_pkg::rot_t           out_r01,
  output rpa_pkg::rot_t           out_r02,
  output rpa_pkg::rot_t           out_r10,
  output rpa_pkg::rot_t           out_r11,
  output rpa_pkg::rot_t           out_r12,
  output rpa_pkg::rot_t           out_r20,
  output rpa_pkg::rot_t           out_r21,
  output rpa_pkg::rot_t           out_r22,
  output rpa_pkg::pose_t_t        out_tx,
  output rpa_pkg::pose_t_t        out_ty,
  output rpa_pkg::pose_t_t        out_tz
);

  logic              in_vld_r;
  logic              in_vld_nxt;
  logic              out_vld_r;
  logic              out_vld_nxt;
  logic              fire;

  rpa_pkg::rot_t     step_rot_r [9];
  rpa_pkg::step_t    step_t_r   [3];
  rpa_pkg::rot_t     pose_rot_r [9];
  rpa_pkg::pose_t_t  pose_t_r   [3];
  rpa_pkg::rot_t     pose_rot_nxt [9];
  rpa_pkg::pose_t_t  pose_t_nxt   [3];
  rpa_pkg::rot_t     out_rot_r  [9];
  rpa_pkg::pose_t_t  out_t_r    [3];

  // advance the input stage into the result register
  assign fire     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || fire;

  always_comb begin
    in_vld_nxt  = in_ready ? in_valid : in_vld_r;
    out_vld_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);
  end

  for (genvar gi = 0; gi < 3; gi++) begin : g_row
    for (genvar gj = 0; gj < 3; gj++) begin : g_col
      logic signed [rpa_pkg::RPROD_W-1:0] p0, p1, p2;
      logic signed [rpa_pkg::RSUM_W-1:0]  sum;
      logic signed [rpa_pkg::RSUM_W-rpa_pkg::FRAC_SHIFT-1:0] rnd;

      assign p0  = pose_rot_r[gi*3+0] * step_rot_r[0*3+gj];
      assign p1  = pose_rot_r[gi*3+1] * step_rot_r[1*3+gj];
      assign p2  = pose_rot_r[gi*3+2] * step_rot_r[2*3+gj];
      assign sum = rpa_pkg::RSUM_W'(p0) + rpa_pkg::RSUM_W'(p1) + rpa_pkg::RSUM_W'(p2)
                 + rpa_pkg::RSUM_W'(rpa_pkg::ROUND_HALF);
      // arithmetic floor shift, then round-half-up is complete
      assign rnd = sum[rpa_pkg::RSUM_W-1:rpa_pkg::FRAC_SHIFT];

      always_comb begin
        if (rnd[rpa_pkg::RSUM_W-rpa_pkg::FRAC_SHIFT-1:rpa_pkg::ROT_W-1] == '0 ||
            rnd[rpa_pkg::RSUM_W-rpa_pkg::FRAC_SHIFT-1:rpa_pkg::ROT_W-1] == '1) begin
          pose_rot_nxt[gi*3+gj] = rnd[rpa_pkg::ROT_W-1:0];
        end else if (rnd[rpa_pkg::RSUM_W-rpa_pkg::FRAC_SHIFT-1]) begin
          pose_rot_nxt[gi*3+gj] = rpa_pkg::ROT_MIN;
        end else begin
          pose_rot_nxt[gi*3+gj] = rpa_pkg::ROT_MAX;
        end
      end
    end

    logic signed [rpa_pkg::TPROD_W-1:0] q0, q1, q2;
    logic signed [rpa_pkg::TSUM_W-1:0]  tsum;
    logic signed [rpa_pkg::TRND_W-1:0]  trnd;
    logic signed [rpa_pkg::TTOT_W-1:0]  ttot;

    assign q0   = pose_rot_r[gi*3+0] * step_t_r[0];
    assign q1   = pose_rot_r[gi*3+1] * step_t_r[1];
    assign q2   = pose_rot_r[gi*3+2] * step_t_r[2];
    assign tsum = rpa_pkg::TSUM_W'(q0) + rpa_pkg::TSUM_W'(q1) + rpa_pkg::TSUM_W'(q2)
                + rpa_pkg::TSUM_W'(rpa_pkg::ROUND_HALF);
    assign trnd = tsum[rpa_pkg::TSUM_W-1:rpa_pkg::FRAC_SHIFT];
    assign ttot = rpa_pkg::TTOT_W'(trnd) + rpa_pkg::TTOT_W'(pose_t_r[gi]);

    always_comb begin
      if (ttot[rpa_pkg::TTOT_W-1] == ttot[rpa_pkg::TTOT_W-2]) begin
        pose_t_nxt[gi] = ttot[rpa_pkg::POSE_T_W-1:0];
      end else if (ttot[rpa_pkg::TTOT_W-1]) begin
        pose_t_nxt[gi] = rpa_pkg::POSE_T_MIN;
      end else begin
        pose_t_nxt[gi] = rpa_pkg::POSE_T_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        pose_rot_r[k] <= (k % 4 == 0) ? rpa_pkg::ONE_Q14 : '0;
      end
      for (int k = 0; k < 3; k++) begin
        pose_t_r[k] <= '0;
      end
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (fire) begin
        pose_rot_r <= pose_rot_nxt;
        pose_t_r   <= pose_t_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      step_rot_r <= '{in_rot_00, in_rot_01, in_rot_02,
                      in_rot_10, in_rot_11, in_rot_12,
                      in_rot_20, in_rot_21, in_rot_22};
      step_t_r   <= '{in_step_tx, in_step_ty, in_step_tz};
    end
    if (fire) begin
      out_rot_r <= pose_rot_nxt;
      out_t_r   <= pose_t_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_r00   = out_rot_r[0];
  assign out_r01   = out_rot_r[1];
  assign out_r02   = out_rot_r[2];
  assign out_r10   = out_rot_r[3];
  assign out_r11   = out_rot_r[4];
  assign out_r12   = out_rot_r[5];
  assign out_r20   = out_rot_r[6];
  assign out_r21   = out_rot_r[7];
  assign out_r22   = out_rot_r[8];
  assign out_tx    = out_t_r[0];
  assign out_ty    = out_t_r[1];
  assign out_tz    = out_t_r[2];

endmodule

// ===== hw/rtl/rpa_checker.sv =====
module rpa_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input rpa_pkg::rot_t           out_r00,
  input rpa_pkg::rot_t           out_r11,
  input rpa_pkg::rot_t           out_r22,
  input rpa_pkg::pose_t_t        out_tx,
  input rpa_pkg::pose_t_t        out_ty,
  input rpa_pkg::pose_t_t        out_tz
);

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result holds its pose
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_r00) && $stable(out_r11)
      && $stable(out_r22) && $stable(out_tx) && $stable(out_ty) && $stable(out_tz))
    else $error("stalled result changed");

  // a request taken behind a stalled result fills the input stage
  a_single_slot: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && out_valid && !out_ready |=> in_ready == out_ready)
    else $error("input stage accepted past its depth");

  // an empty result stage never blocks a request
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request blocked with no result pending");

endmodule

bind rigid_pose_accumulator rpa_checker u_rpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_r00   (out_r00),
  .out_r11   (out_r11),
  .out_r22   (out_r22),
  .out_tx    (out_tx),
  .out_ty    (out_ty),
  .out_tz    (out_tz)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int  Q14_ONE        = rpa_pkg::ONE_Q14;
  localparam int  Q14_MAX        = rpa_pkg::ROT_MAX;
  localparam int  Q14_MIN        = rpa_pkg::ROT_MIN;
  localparam int  Q14_HALF       = 8192;
  localparam int  STEP_MAX       = 32'sh7FFF_FFFF;
  localparam int  STEP_MIN       = 32'sh8000_0000;
  localparam int  WATCHDOG_LIMIT = 1000;

  typedef logic [8:0][rpa_pkg::ROT_W-1:0]  rot_mat_t;
  typedef logic [2:0][rpa_pkg::STEP_W-1:0] step_vec_t;

  typedef struct packed {
    logic [8:0][rpa_pkg::ROT_W-1:0]    r;
    logic [2:0][rpa_pkg::POSE_T_W-1:0] t;
  } pose_word_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  rot_mat_t  req_rot;
  step_vec_t req_step;
  logic      out_valid;
  logic      out_ready;
  wire [8:0][rpa_pkg::ROT_W-1:0]    dut_rot;
  wire [2:0][rpa_pkg::POSE_T_W-1:0] dut_tr;

  // predicted pose after every accepted request
  longint     pose_rot [9];
  longint     pose_tr  [3];
  pose_word_t pose_expected_q [$];
  pose_word_t head_pose;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int steps_sent;
  int poses_checked;
  int error_count;
  int quiet_cycles;

  rigid_pose_accumulator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rot_00  (req_rot[0]),
    .in_rot_01  (req_rot[1]),
    .in_rot_02  (req_rot[2]),
    .in_rot_10  (req_rot[3]),
    .in_rot_11  (req_rot[4]),
    .in_rot_12  (req_rot[5]),
    .in_rot_20  (req_rot[6]),
    .in_rot_21  (req_rot[7]),
    .in_rot_22  (req_rot[8]),
    .in_step_tx (req_step[0]),
    .in_step_ty (req_step[1]),
    .in_step_tz (req_step[2]),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_r00    (dut_rot[0]),
    .out_r01    (dut_rot[1]),
    .out_r02    (dut_rot[2]),
    .out_r10    (dut_rot[3]),
    .out_r11    (dut_rot[4]),
    .out_r12    (dut_rot[5]),
    .out_r20    (dut_rot[6]),
    .out_r21    (dut_rot[7]),
    .out_r22    (dut_rot[8]),
    .out_tx     (dut_tr[0]),
    .out_ty     (dut_tr[1]),
    .out_tz     (dut_tr[2])
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint clamp_to(input longint x, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -(longint'(1) <<< (w - 1));
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  function automatic void reset_pose();
    for (int i = 0; i < 9; i++) pose_rot[i] = (i % 4 == 0) ? Q14_ONE : 0;
    for (int i = 0; i < 3; i++) pose_tr[i] = 0;
  endfunction

  // new R = R * Rs, new t = R * ts + t, both from the old R
  function automatic void compose_step(input rot_mat_t m, input step_vec_t v);
    longint     rs [9];
    longint     ts [3];
    longint     nr [9];
    longint     nt [3];
    longint     acc;
    pose_word_t w;
    for (int i = 0; i < 9; i++) rs[i] = $signed(m[i]);
    for (int i = 0; i < 3; i++) ts[i] = $signed(v[i]);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += pose_rot[i*3+k] * rs[k*3+j];
        nr[i*3+j] = clamp_to((acc + Q14_HALF) >>> 14, rpa_pkg::ROT_W);
      end
      acc = 0;
      for (int k = 0; k < 3; k++) acc += pose_rot[i*3+k] * ts[k];
      nt[i] = clamp_to(((acc + Q14_HALF) >>> 14) + pose_tr[i], rpa_pkg::POSE_T_W);
    end
    for (int i = 0; i < 9; i++) begin
      pose_rot[i] = nr[i];
      w.r[i] = nr[i][rpa_pkg::ROT_W-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      pose_tr[i] = nt[i];
      w.t[i] = nt[i][rpa_pkg::POSE_T_W-1:0];
    end
    pose_expected_q = {pose_expected_q, w};
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic rot_mat_t rows(input int a00, input int a01, input int a02,
                                    input int a10, input int a11, input int a12,
                                    input int a20, input int a21, input int a22);
    rot_mat_t m;
    m[0] = 16'(a00); m[1] = 16'(a01); m[2] = 16'(a02);
    m[3] = 16'(a10); m[4] = 16'(a11); m[5] = 16'(a12);
    m[6] = 16'(a20); m[7] = 16'(a21); m[8] = 16'(a22);
    return m;
  endfunction

  function automatic rot_mat_t diag_rot(input int d);
    return rows(d, 0, 0, 0, d, 0, 0, 0, d);
  endfunction

  function automatic step_vec_t vec3(input int x, input int y, input int z);
    step_vec_t v;
    v[0] = 32'(x);
    v[1] = 32'(y);
    v[2] = 32'(z);
    return v;
  endfunction

  function automatic step_vec_t rand_step_vec();
    step_vec_t v;
    int        pick;
    for (int k = 0; k < 3; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        v[k] = 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
      end else if (pick < 80) begin
        v[k] = $urandom;
      end else begin
        case ($urandom_range(0, 4))
          0: v[k] = 32'(STEP_MAX);
          1: v[k] = 32'(STEP_MIN);
          2: v[k] = '0;
          3: v[k] = 32'd1;
          default: v[k] = '1;
        endcase
      end
    end
    return v;
  endfunction

  // +1/-1 pattern of the gain matrix: rows (1,1,1), (1,-1,1), (1,1,-1)
  function automatic int gain_sign(input int r, input int k);
    return (r != 0 && k == r) ? -1 : 1;
  endfunction

  // roughly twice that pattern, invertible, every entry at a rotation extreme
  function automatic rot_mat_t gain_rot();
    rot_mat_t m;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i*3+j] = 16'(gain_sign(i, j) > 0 ? Q14_MAX : Q14_MIN);
    return m;
  endfunction

  function automatic rot_mat_t gain_inverse();
    return rows(0, 4096, 4096, 4096, -4096, 0, 4096, 0, -4096);
  endfunction

  function automatic rot_mat_t signed_perm();
    rot_mat_t m;
    int       p;
    int       col;
    m = '0;
    p = $urandom_range(0, 5);
    for (int i = 0; i < 3; i++) begin
      col = (p < 3) ? (i + p) % 3 : (p - i + 3) % 3;
      m[i*3+col] = 16'($urandom_range(0, 1) ? -Q14_ONE : Q14_ONE);
    end
    return m;
  endfunction

  // a few degrees about one axis, cosine from the small-angle series
  function automatic rot_mat_t small_turn();
    rot_mat_t m;
    int       s;
    int       c;
    int       a;
    int       u;
    int       w;
    s = int'($urandom_range(0, 4000)) - 2000;
    c = Q14_ONE - (s * s) / 32768;
    a = $urandom_range(0, 2);
    u = (a + 1) % 3;
    w = (a + 2) % 3;
    m = diag_rot(Q14_ONE);
    m[u*3+u] = 16'(c);
    m[u*3+w] = 16'(-s);
    m[w*3+u] = 16'(s);
    m[w*3+w] = 16'(c);
    return m;
  endfunction

  // transpose of the current pose: pulls a near-orthonormal pose back to identity
  function automatic rot_mat_t realign_rot();
    rot_mat_t m;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i*3+j] = pose_rot[j*3+i][rpa_pkg::ROT_W-1:0];
    return m;
  endfunction

  function automatic rot_mat_t noise_rot();
    rot_mat_t m;
    for (int k = 0; k < 9; k++) m[k] = 16'($urandom);
    return m;
  endfunction

  task automatic send_step(input rot_mat_t m, input step_vec_t v);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_rot  <= m;
    req_step <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    compose_step(m, v);
    steps_sent++;
  endtask

  task automatic rotation_run(input int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) send_step(signed_perm(), rand_step_vec());
      else if (pick < 8) send_step(small_turn(), rand_step_vec());
      else send_step(realign_rot(), rand_step_vec());
    end
  endtask

  // scale each axis twice to saturate, then halve: a signed permutation comes back exactly
  task automatic scale_excursion();
    int d [3];
    for (int k = 0; k < 3; k++) d[k] = $urandom_range(0, 1) ? Q14_MAX : Q14_MIN;
    repeat (2) send_step(rows(d[0], 0, 0, 0, d[1], 0, 0, 0, d[2]), rand_step_vec());
    send_step(diag_rot(Q14_HALF), rand_step_vec());
  endtask

  // push one translation component into saturation and hold it there a little
  task automatic drive_translation(input int row, input int dir);
    step_vec_t  v;
    longint     target;
    logic [31:0] mag;
    int         n;
    int         tail;
    target = (dir > 0) ? longint'(rpa_pkg::POSE_T_MAX) : longint'(rpa_pkg::POSE_T_MIN);
    send_step(realign_rot(), rand_step_vec());
    send_step(gain_rot(), rand_step_vec());
    n = 0;
    tail = 0;
    while (n < 110 && tail < 4) begin
      for (int k = 0; k < 3; k++) begin
        mag = 32'(STEP_MAX) - 32'($urandom_range(0, 1 << 24));
        v[k] = (dir * gain_sign(row, k) > 0) ? mag : -mag;
      end
      send_step(diag_rot(Q14_ONE), v);
      if (pose_tr[row] == target) tail++;
      n++;
    end
    send_step(gain_inverse(), rand_step_vec());
    send_step(realign_rot(), rand_step_vec());
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    send_step(diag_rot(Q14_ONE), vec3(0, 0, 0));
    send_step(diag_rot(Q14_ONE), vec3(STEP_MAX, STEP_MIN, 1));
    // quarter turn about z and back
    send_step(rows(0, -Q14_ONE, 0, Q14_ONE, 0, 0, 0, 0, Q14_ONE), vec3(65536, -65536, 0));
    send_step(rows(0, Q14_ONE, 0, -Q14_ONE, 0, 0, 0, 0, Q14_ONE), vec3(0, 0, -1));
    // grow past the rotation range both ways, then halve back on a rounding tie
    send_step(diag_rot(Q14_MAX), vec3(1, -1, 0));
    send_step(diag_rot(Q14_MAX), rand_step_vec());
    send_step(diag_rot(Q14_MIN), rand_step_vec());
    send_step(diag_rot(Q14_MIN), rand_step_vec());
    send_step(diag_rot(Q14_HALF), rand_step_vec());
    // half-scale pose makes odd translations land on ties
    send_step(diag_rot(Q14_HALF), vec3(0, 0, 0));
    send_step(diag_rot(Q14_ONE), vec3(1, -1, 3));
    send_step(diag_rot(Q14_MAX), vec3(STEP_MIN, STEP_MAX, 0));
    // non-orthonormal shear and its inverse
    send_step(rows(Q14_ONE, Q14_ONE, 0, 0, Q14_ONE, 0, 0, 0, Q14_ONE), rand_step_vec());
    send_step(rows(Q14_ONE, -Q14_ONE, 0, 0, Q14_ONE, 0, 0, 0, Q14_ONE), rand_step_vec());
    send_step(gain_rot(), vec3(STEP_MIN, STEP_MIN, STEP_MAX));
    send_step(gain_inverse(), vec3(-1, -1, -1));
    send_step(realign_rot(), rand_step_vec());
  endtask

  task automatic test_rotation_runs();
    int start;
    start = steps_sent;
    while (steps_sent - start < 190) begin
      if ($urandom_range(0, 3) == 0) scale_excursion();
      else rotation_run($urandom_range(4, 12));
    end
  endtask

  task automatic test_translation_saturation();
    int start;
    send_idle_pct = 66;
    recv_idle_pct = 35;
    start = steps_sent;
    drive_translation($urandom_range(0, 2), 1);
    rotation_run(8);
    drive_translation($urandom_range(0, 2), -1);
    while (steps_sent - start < 140) rotation_run($urandom_range(4, 12));
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 60;
    repeat (12) send_step(signed_perm(), rand_step_vec());
  endtask

  task automatic test_noise();
    rotation_run(30);
    repeat (50) send_step(noise_rot(), rand_step_vec());
  endtask

  // ---------------------------------------------------------------- result side

  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pose_expected_q.size() == 0) begin
        error_count++;
        $display("%0t: pose result with no request outstanding", $time);
      end else begin
        head_pose = pose_expected_q.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (dut_rot[i] !== head_pose.r[i]) begin
            error_count++;
            $display("%0t: rotation[%0d] expected %0d got %0d", $time, i,
                     $signed(head_pose.r[i]), $signed(dut_rot[i]));
          end
        end
        for (int i = 0; i < 3; i++) begin
          if (dut_tr[i] !== head_pose.t[i]) begin
            error_count++;
            $display("%0t: translation[%0d] expected %0d got %0d", $time, i,
                     $signed(head_pose.t[i]), $signed(dut_tr[i]));
          end
        end
        poses_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("rigid_pose_accumulator test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    req_rot       = '0;
    req_step      = '0;
    hold_left     = 0;
    steps_sent    = 0;
    poses_checked = 0;
    error_count   = 0;
    quiet_cycles  = 0;
    send_idle_pct = 35;
    recv_idle_pct = 66;
    reset_pose();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_rotation_runs();
    test_translation_saturation();
    test_backpressure();
    test_noise();

    in_valid <= 1'b0;
    while (pose_expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d pose steps sent, %0d updated poses checked, %0d mismatches", steps_sent,
             poses_checked, error_count);
    $display("covered: turns, rotation and translation saturation, rounding ties, shear, "
             , "long output stall, random noise");
    if (error_count == 0) begin
      $display("rigid_pose_accumulator test passed");
    end else begin
      $display("rigid_pose_accumulator test failed");
    end
    $finish;
  end

endmodule
